>>> hw/rtl/tdmsa_pkg.sv
// Shared types, codes and the unlock sequence table for the drive mode arbiter.
package tdmsa_pkg;

  // Fixed item field widths
  localparam int BTN_W    = 11;
  localparam int IDX_W    = 4;
  localparam int TS_W     = 32;
  localparam int LVL_W    = 2;
  localparam int PAD_W    = 2;
  localparam int SPEED_W  = 16;
  localparam int ACT_W    = 2;
  localparam int CODE_W   = 15;
  localparam int STEP_W   = 5;
  localparam int IN_DW    = 56;
  localparam int OUT_DW   = 24;

  // Configuration port
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;
  localparam logic [2:0] REG_DEADMAN  = 3'd0;
  localparam logic [2:0] REG_AUTO     = 3'd1;
  localparam logic [2:0] REG_OBSTACLE = 3'd2;
  localparam logic [2:0] REG_TIMEOUT  = 3'd3;
  localparam logic [2:0] REG_SLOW     = 3'd4;

  // Report kinds (tuser)
  localparam logic CMD_GAMEPAD = 1'b0;
  localparam logic CMD_TERRAIN = 1'b1;

  // Terrain levels
  localparam logic [LVL_W-1:0] TERR_SAFE    = 2'd0;
  localparam logic [LVL_W-1:0] TERR_SLOW    = 2'd1;
  localparam logic [LVL_W-1:0] TERR_STOP    = 2'd2;
  localparam logic [LVL_W-1:0] TERR_UNKNOWN = 2'd3;

  // Actions
  localparam logic [ACT_W-1:0] ACT_CONTINUE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SLOW     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PAUSE    = 2'd2;

  // Direction pad values
  localparam logic [PAD_W-1:0] PAD_POS = 2'b01;
  localparam logic [PAD_W-1:0] PAD_NEG = 2'b11;

  // Press code bits
  localparam logic [CODE_W-1:0] PRESS_BTN0  = 15'h0001;
  localparam logic [CODE_W-1:0] PRESS_BTN1  = 15'h0002;
  localparam logic [CODE_W-1:0] PRESS_LEFT  = 15'h0800;
  localparam logic [CODE_W-1:0] PRESS_RIGHT = 15'h1000;
  localparam logic [CODE_W-1:0] PRESS_UP    = 15'h2000;
  localparam logic [CODE_W-1:0] PRESS_DOWN  = 15'h4000;

  // Expected press code at unlock step k: odd steps are all released,
  // even steps walk a ten-entry press pattern
  function automatic logic [CODE_W-1:0] step_code(input logic [STEP_W-1:0] k);
    logic [CODE_W-1:0] c;
    c = '0;
    if (!k[0]) begin
      case (k[4:1])
        4'd0, 4'd1, 4'd10, 4'd11: c = PRESS_UP;
        4'd2, 4'd3, 4'd12, 4'd13: c = PRESS_DOWN;
        4'd4, 4'd6, 4'd14:        c = PRESS_LEFT;
        4'd5, 4'd7, 4'd15:        c = PRESS_RIGHT;
        4'd8:                     c = PRESS_BTN1;
        4'd9:                     c = PRESS_BTN0;
        default:                  c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/teleop_drive_mode_safety_arbiter.sv
// Top level of the tele-operation drive mode safety arbiter.
//
// Usage:
//   in_*  stream carries reports. in_tuser selects the kind: 0 gamepad,
//         1 terrain safety report. A terrain report only updates the stored
//         terrain level and gives no result; a gamepad report gives one.
//   out_* stream carries one result per gamepad report.
//   cfg_* APB-style port holds the five setup registers at byte offsets
//         0,4,8,12,16; pready is always high. Write only while idle.
// Timing: an item is captured in an input register, then the sequence
//   matching and mode logic loads the output register from it, so a result
//   is valid on out_* once it has passed both registers. One item per cycle
//   is sustained while out_tready stays high; the state update loop sets it.
// Reset (rst_n low, synchronous): both stages empty, terrain level stop,
//   manual mode, unlock sequence at its start, registers at defaults.
// Stall: while out_tready is low the result holds; one more item waits in
//   the input register, then in_tready drops. Terrain reports keep flowing
//   past a stalled output only while the input register can drain.
module teleop_drive_mode_safety_arbiter #(
  parameter int BUTTON_COUNT    = 11,
  parameter int SEQUENCE_LENGTH = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // tdata: button_bits[10:0], pad_horizontal[12:11], pad_vertical[14:13],
  //        timestamp[46:15], terrain_level[48:47], zero fill [55:49]
  input  logic [tdmsa_pkg::IN_DW-1:0]   in_tdata,
  // tuser: cmd
  input  logic                          in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // tdata: action[1:0], speed_limit[17:2], in_automatic[18], unlocked[19],
  //        zero fill [23:20]
  output logic [tdmsa_pkg::OUT_DW-1:0]  out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tdmsa_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [tdmsa_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [tdmsa_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);
  import tdmsa_pkg::*;

  localparam int POS_W = $clog2(SEQUENCE_LENGTH + 1);
  localparam logic [POS_W-1:0] SEQ_LEN = POS_W'(SEQUENCE_LENGTH);
  localparam logic [BTN_W-1:0] BTN_MASK = BTN_W'((1 << BUTTON_COUNT) - 1);

  // Configuration registers
  logic [IDX_W-1:0]   deadman_idx_r, auto_idx_r, obstacle_idx_r;
  logic [TS_W-1:0]    seq_timeout_r;
  logic [SPEED_W-1:0] slow_limit_r;
  logic [2:0]         cfg_reg;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_reg    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadman_idx_r  <= IDX_W'(1);
      auto_idx_r     <= IDX_W'(2);
      obstacle_idx_r <= IDX_W'(3);
      seq_timeout_r  <= TS_W'(1000);
      slow_limit_r   <= SPEED_W'(128);
    end else if (cfg_wr) begin
      case (cfg_reg)
        REG_DEADMAN:  deadman_idx_r  <= cfg_pwdata[IDX_W-1:0];
        REG_AUTO:     auto_idx_r     <= cfg_pwdata[IDX_W-1:0];
        REG_OBSTACLE: obstacle_idx_r <= cfg_pwdata[IDX_W-1:0];
        REG_TIMEOUT:  seq_timeout_r  <= cfg_pwdata[TS_W-1:0];
        REG_SLOW:     slow_limit_r   <= cfg_pwdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_reg)
      REG_DEADMAN:  cfg_prdata = CFG_DW'(deadman_idx_r);
      REG_AUTO:     cfg_prdata = CFG_DW'(auto_idx_r);
      REG_OBSTACLE: cfg_prdata = CFG_DW'(obstacle_idx_r);
      REG_TIMEOUT:  cfg_prdata = seq_timeout_r;
      REG_SLOW:     cfg_prdata = CFG_DW'(slow_limit_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // Input stage and output stage handshake
  logic              s1_v_r, s1_user_r;
  logic [48:0]       s1_data_r;
  logic              out_v_r;
  logic [OUT_DW-1:0] out_data_r;
  logic              out_free, s1_go, load_out;

  assign out_free   = !out_v_r || out_tready;
  assign s1_go      = s1_v_r && ((s1_user_r == CMD_TERRAIN) || out_free);
  assign load_out   = s1_go && (s1_user_r == CMD_GAMEPAD);
  assign in_tready  = !s1_v_r || s1_go;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_user_r <= in_tuser;
      s1_data_r <= in_tdata[48:0];
    end
  end

  // Unpack the held item
  logic [BTN_W-1:0] bits;
  logic [PAD_W-1:0] pad_h, pad_v;
  logic [TS_W-1:0]  ts;
  logic [LVL_W-1:0] level;

  assign bits  = s1_data_r[10:0] & BTN_MASK;
  assign pad_h = s1_data_r[12:11];
  assign pad_v = s1_data_r[14:13];
  assign ts    = s1_data_r[46:15];
  assign level = s1_data_r[48:47];

  // Arbiter state
  logic [LVL_W-1:0] terrain_r, terrain_nxt;
  logic             auto_mode_r, auto_mode_nxt;
  logic             auto_prev_r, dead_prev_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [TS_W-1:0]  last_ts_r, last_ts_nxt;

  // Unlock sequence matcher
  logic [TS_W-1:0]   dt;
  logic              seq_open, timed_out;
  logic [CODE_W-1:0] code, prev_code, cur_code;

  always_comb begin
    dt        = ts - last_ts_r;
    seq_open  = pos_r < SEQ_LEN;
    timed_out = (dt > seq_timeout_r) && seq_open;
    code      = CODE_W'(bits);
    if (pad_h == PAD_POS) code = code | PRESS_LEFT;
    if (pad_h == PAD_NEG) code = code | PRESS_RIGHT;
    if (pad_v == PAD_POS) code = code | PRESS_UP;
    if (pad_v == PAD_NEG) code = code | PRESS_DOWN;
    prev_code = (pos_r != '0) ? step_code(STEP_W'(pos_r - POS_W'(1))) : '0;
    cur_code  = seq_open ? step_code(STEP_W'(pos_r)) : '0;
    pos_nxt     = pos_r;
    last_ts_nxt = last_ts_r;
    if (timed_out) begin
      pos_nxt     = '0;
      last_ts_nxt = ts;
    end else if (code != prev_code && code != cur_code && code != '0) begin
      pos_nxt = '0;
    end else if (code == cur_code && seq_open) begin
      pos_nxt     = pos_r + POS_W'(1);
      last_ts_nxt = ts;
    end
  end

  // Button decode, mode update and action select
  logic [15:0]      bits_wide;
  logic [BTN_W-1:0] skip_mask;
  logic             auto_p, dead_p, other, unlocked;
  logic [ACT_W-1:0] action;
  logic [SPEED_W-1:0] speed;

  always_comb begin
    bits_wide = {5'b0, bits};
    auto_p    = bits_wide[auto_idx_r];
    dead_p    = bits_wide[deadman_idx_r];
    skip_mask = BTN_W'(16'd1 << deadman_idx_r) | BTN_W'(16'd1 << auto_idx_r)
              | BTN_W'(16'd1 << obstacle_idx_r);
    other     = |(bits & ~skip_mask);
    unlocked  = (pos_nxt == SEQ_LEN);

    auto_mode_nxt = auto_mode_r;
    if (!auto_mode_r) begin
      if (auto_p && !auto_prev_r) auto_mode_nxt = 1'b1;
    end else if (other || (auto_p && !auto_prev_r) || (dead_p && !dead_prev_r)) begin
      auto_mode_nxt = 1'b0;
    end

    speed = '0;
    if (dead_p || unlocked) begin
      action = ACT_CONTINUE;
    end else if (auto_mode_nxt) begin
      case (terrain_r)
        TERR_SAFE: action = ACT_CONTINUE;
        TERR_SLOW: begin
          action = ACT_SLOW;
          speed  = slow_limit_r;
        end
        default:   action = ACT_PAUSE;
      endcase
    end else begin
      action = ACT_PAUSE;
    end

    terrain_nxt = terrain_r;
    if (level != TERR_UNKNOWN) terrain_nxt = level;
  end

  // State registers, updated as each held item leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      terrain_r   <= TERR_STOP;
      auto_mode_r <= 1'b0;
      auto_prev_r <= 1'b0;
      dead_prev_r <= 1'b0;
      pos_r       <= '0;
      last_ts_r   <= '0;
    end else if (s1_go) begin
      if (s1_user_r == CMD_TERRAIN) begin
        terrain_r <= terrain_nxt;
      end else begin
        auto_mode_r <= auto_mode_nxt;
        auto_prev_r <= auto_p;
        dead_prev_r <= dead_p;
        pos_r       <= pos_nxt;
        last_ts_r   <= last_ts_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load_out) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {4'b0, unlocked, auto_mode_nxt, speed, action};
    end
  end

endmodule

>>> bench/tb.sv
// Self-checking testbench for the drive mode safety arbiter: predicts and checks every result.
`timescale 1ns / 1ps

module tb;
  import tdmsa_pkg::*;

  localparam int UNLOCK_LEN   = 20;
  localparam int BUTTONS      = 11;
  localparam int LIMIT_CYCLES = 300000;
  localparam int MAX_REPORTED = 10;
  localparam int STEP_WINDOW  = 3000;
  localparam int EXP_AW       = 6;
  localparam int EXP_DEPTH    = 1 << EXP_AW;

  // pad value that decodes as neither direction
  localparam logic [PAD_W-1:0] PAD_ALT = 2'b10;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [SPEED_W-1:0] speed;
    logic               auto_on;
    logic               unlocked;
  } drive_verdict_t;

  logic                 clk;
  logic                 rst_n;
  logic [IN_DW-1:0]     in_tdata;
  logic                 in_tuser;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [OUT_DW-1:0]    out_tdata;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic                 cfg_psel;
  logic                 cfg_penable;
  logic                 cfg_pwrite;
  logic [CFG_AW-1:0]    cfg_paddr;
  logic [CFG_DW-1:0]    cfg_pwdata;
  logic [CFG_DW-1:0]    cfg_prdata;
  logic                 cfg_pready;

  // predictor copy of the setup registers
  logic [IDX_W-1:0]     deadman_idx;
  logic [IDX_W-1:0]     auto_idx;
  logic [IDX_W-1:0]     obstacle_idx;
  logic [TS_W-1:0]      step_timeout;
  logic [SPEED_W-1:0]   slow_speed;

  // predictor state
  logic [LVL_W-1:0]     terrain;
  logic                 auto_mode;
  logic                 auto_held;
  logic                 deadman_held;
  int unsigned          unlock_pos;
  logic [TS_W-1:0]      last_step_ts;

  // predicted results in a ring, oldest at exp_taken
  drive_verdict_t       expected_verdicts[EXP_DEPTH];
  int unsigned          exp_sent = 0;
  int unsigned          exp_taken = 0;
  int                   mismatches = 0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   stall_budget = 0;
  int                   stall_served = 0;
  int                   cycle_count = 0;
  int                   unlock_run = 0;

  teleop_drive_mode_safety_arbiter DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("teleop_drive_mode_safety_arbiter regression: fail");
      $finish;
    end
  end

  // result side: random stalls, plus long holds requested through stall_budget
  always @(negedge clk) begin
    if (stall_served < stall_budget) begin
      out_tready   <= 1'b0;
      stall_served <= stall_served + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [BTN_W-1:0] button_bit(input logic [IDX_W-1:0] idx);
    logic [BTN_W-1:0] m;
    m = '0;
    if (idx < BUTTONS) m[idx] = 1'b1;
    return m;
  endfunction

  // unlock pattern: releases on odd steps, a ten-press cycle on even steps
  function automatic logic [CODE_W-1:0] unlock_step(input int unsigned k);
    if (k % 2 == 1) return '0;
    case ((k / 2) % 10)
      0, 1:    return PRESS_UP;
      2, 3:    return PRESS_DOWN;
      4, 6:    return PRESS_LEFT;
      5, 7:    return PRESS_RIGHT;
      8:       return PRESS_BTN1;
      default: return PRESS_BTN0;
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] press_code(input logic [BTN_W-1:0] bits,
                                                   input logic [PAD_W-1:0] ph,
                                                   input logic [PAD_W-1:0] pv);
    logic [CODE_W-1:0] code;
    code = '0;
    code[BTN_W-1:0] = bits;
    if (ph == PAD_POS) code = code | PRESS_LEFT;
    if (ph == PAD_NEG) code = code | PRESS_RIGHT;
    if (pv == PAD_POS) code = code | PRESS_UP;
    if (pv == PAD_NEG) code = code | PRESS_DOWN;
    return code;
  endfunction

  // one gamepad report through the predictor: unlock matcher, mode, action
  function automatic drive_verdict_t arbitrate(input logic [BTN_W-1:0] bits,
                                               input logic [PAD_W-1:0] ph,
                                               input logic [PAD_W-1:0] pv,
                                               input logic [TS_W-1:0]  ts);
    drive_verdict_t    v;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] prev_step;
    logic [CODE_W-1:0] cur_step;
    logic [TS_W-1:0]   gap;
    logic              auto_now;
    logic              dead_now;
    logic              other_now;
    logic              auto_rise;
    logic              dead_rise;
    gap = ts - last_step_ts;
    if (gap > step_timeout && unlock_pos < UNLOCK_LEN) begin
      unlock_pos   = 0;
      last_step_ts = ts;
    end else begin
      code      = press_code(bits, ph, pv);
      prev_step = (unlock_pos > 0) ? unlock_step(unlock_pos - 1) : '0;
      cur_step  = (unlock_pos < UNLOCK_LEN) ? unlock_step(unlock_pos) : '0;
      if (code != prev_step && code != cur_step && code != '0) begin
        unlock_pos = 0;
      end else if (code == cur_step && unlock_pos < UNLOCK_LEN) begin
        unlock_pos   = unlock_pos + 1;
        last_step_ts = ts;
      end
    end
    v.unlocked = (unlock_pos == UNLOCK_LEN);

    auto_now  = |(bits & button_bit(auto_idx));
    dead_now  = |(bits & button_bit(deadman_idx));
    other_now = |(bits & ~(button_bit(deadman_idx) | button_bit(auto_idx) |
                           button_bit(obstacle_idx)));
    auto_rise = auto_now && !auto_held;
    dead_rise = dead_now && !deadman_held;

    if (!auto_mode) begin
      if (auto_rise) auto_mode = 1'b1;
    end else if (other_now || auto_rise || dead_rise) begin
      auto_mode = 1'b0;
    end

    v.speed = '0;
    if (dead_now || v.unlocked) begin
      v.action = ACT_CONTINUE;
    end else if (!auto_mode) begin
      v.action = ACT_PAUSE;
    end else if (terrain == TERR_SAFE) begin
      v.action = ACT_CONTINUE;
    end else if (terrain == TERR_SLOW) begin
      v.action = ACT_SLOW;
      v.speed  = slow_speed;
    end else begin
      v.action = ACT_PAUSE;
    end
    v.auto_on    = auto_mode;
    auto_held    = auto_now;
    deadman_held = dead_now;
    return v;
  endfunction

  // queue a predicted result behind the ones already waiting
  function automatic void expect_verdict(input drive_verdict_t v);
    expected_verdicts[EXP_AW'(exp_sent)] = v;
    exp_sent++;
  endfunction

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    if (mismatches < MAX_REPORTED)
      $display("cycle %0d: %s mismatch, expected %0h, got %0h", cycle_count, what, want, got);
    mismatches++;
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    drive_verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_taken == exp_sent) begin
        note_mismatch("unexpected item", '0, 32'(out_tdata));
      end else begin
        want = expected_verdicts[EXP_AW'(exp_taken)];
        exp_taken++;
        if (out_tdata[1:0] != want.action)
          note_mismatch("action", 32'(want.action), 32'(out_tdata[1:0]));
        if (out_tdata[17:2] != want.speed)
          note_mismatch("speed_limit", 32'(want.speed), 32'(out_tdata[17:2]));
        if (out_tdata[18] != want.auto_on)
          note_mismatch("in_automatic", 32'(want.auto_on), 32'(out_tdata[18]));
        if (out_tdata[19] != want.unlocked)
          note_mismatch("unlocked", 32'(want.unlocked), 32'(out_tdata[19]));
        if (out_tdata[23:20] != '0)
          note_mismatch("zero fill", '0, 32'(out_tdata[23:20]));
      end
    end
  end

  // offer one item, wait for the handshake, then predict
  task automatic send_report(input logic cmd, input logic [BTN_W-1:0] bits,
                             input logic [PAD_W-1:0] ph, input logic [PAD_W-1:0] pv,
                             input logic [TS_W-1:0] ts, input logic [LVL_W-1:0] lvl);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tuser  <= cmd;
    in_tdata  <= {7'b0, lvl, ts, pv, ph, bits};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_TERRAIN) begin
      if (lvl != TERR_UNKNOWN) terrain = lvl;
    end else begin
      expect_verdict(arbitrate(bits, ph, pv, ts));
    end
  endtask

  task automatic send_pad(input logic [BTN_W-1:0] bits, input logic [PAD_W-1:0] ph,
                          input logic [PAD_W-1:0] pv, input logic [TS_W-1:0] ts);
    send_report(CMD_GAMEPAD, bits, ph, pv, ts, LVL_W'($urandom_range(3)));
  endtask

  // terrain report; the unused fields carry noise
  task automatic send_terrain(input logic [LVL_W-1:0] lvl);
    send_report(CMD_TERRAIN, BTN_W'($urandom), PAD_W'($urandom), PAD_W'($urandom),
                $urandom, lvl);
  endtask

  // stop offering and wait until every result is in, plus pipeline slack
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (exp_taken != exp_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_DEADMAN:  deadman_idx  = value[IDX_W-1:0];
      REG_AUTO:     auto_idx     = value[IDX_W-1:0];
      REG_OBSTACLE: obstacle_idx = value[IDX_W-1:0];
      REG_TIMEOUT:  step_timeout = value[TS_W-1:0];
      REG_SLOW:     slow_speed   = value[SPEED_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic write_setup(input logic [IDX_W-1:0] dead, input logic [IDX_W-1:0] aut,
                             input logic [IDX_W-1:0] obst, input logic [TS_W-1:0] timeout,
                             input logic [SPEED_W-1:0] slow);
    drain_results();
    write_reg(REG_DEADMAN, CFG_DW'(dead));
    write_reg(REG_AUTO, CFG_DW'(aut));
    write_reg(REG_OBSTACLE, CFG_DW'(obst));
    write_reg(REG_TIMEOUT, timeout);
    write_reg(REG_SLOW, CFG_DW'(slow));
  endtask

  task automatic press_to_fields(input logic [CODE_W-1:0] code, output logic [BTN_W-1:0] bits,
                                 output logic [PAD_W-1:0] ph, output logic [PAD_W-1:0] pv);
    bits = code[BTN_W-1:0];
    if (|(code & PRESS_LEFT))       ph = PAD_POS;
    else if (|(code & PRESS_RIGHT)) ph = PAD_NEG;
    else                            ph = ($urandom_range(3) == 0) ? PAD_ALT : '0;
    if (|(code & PRESS_UP))         pv = PAD_POS;
    else if (|(code & PRESS_DOWN))  pv = PAD_NEG;
    else                            pv = ($urandom_range(3) == 0) ? PAD_ALT : '0;
  endtask

  // one random item: terrain report, unlock attempt, or mode button traffic
  task automatic send_random_report();
    logic [CODE_W-1:0] code;
    logic [BTN_W-1:0]  bits;
    logic [PAD_W-1:0]  ph;
    logic [PAD_W-1:0]  pv;
    logic [TS_W-1:0]   ts;
    int unsigned       window;
    window = (step_timeout > STEP_WINDOW) ? STEP_WINDOW : step_timeout;
    if ($urandom_range(99) < 12) begin
      send_terrain(LVL_W'($urandom_range(3)));
    end else begin
      if (unlock_run == 0 && $urandom_range(99) < 6) unlock_run = int'($urandom_range(50, 30));
      if (unlock_run > 0) begin
        unlock_run--;
        if ($urandom_range(99) < 97) begin
          // next step in time, or keep holding the previous one
          if (unlock_pos < UNLOCK_LEN && $urandom_range(99) < 85)
            code = unlock_step(unlock_pos);
          else if (unlock_pos > 0)
            code = unlock_step(unlock_pos - 1);
          else
            code = '0;
          press_to_fields(code, bits, ph, pv);
          ts = last_step_ts + $urandom_range(window);
        end else if (step_timeout != '1 && $urandom_range(1) == 0) begin
          // right step, too late
          code = (unlock_pos < UNLOCK_LEN) ? unlock_step(unlock_pos) : '0;
          press_to_fields(code, bits, ph, pv);
          ts = last_step_ts + step_timeout + 1;
        end else begin
          bits = BTN_W'($urandom);
          ph   = PAD_W'($urandom);
          pv   = PAD_W'($urandom);
          ts   = last_step_ts + $urandom_range(window);
        end
      end else begin
        bits = '0;
        if ($urandom_range(3) == 0) bits = bits | button_bit(deadman_idx);
        if ($urandom_range(2) == 0) bits = bits | button_bit(auto_idx);
        if ($urandom_range(3) == 0) bits = bits | button_bit(obstacle_idx);
        if ($urandom_range(7) == 0) bits = bits | BTN_W'($urandom);
        ph = ($urandom_range(7) == 0) ? PAD_W'($urandom_range(3)) : '0;
        pv = ($urandom_range(7) == 0) ? PAD_W'($urandom_range(3)) : '0;
        ts = ($urandom_range(4) == 0) ? $urandom : last_step_ts + $urandom_range(window);
      end
      send_pad(bits, ph, pv, ts);
    end
  endtask

  // terrain levels, mode edges, field extremes and the matcher's special cases
  task automatic test_directed_reports();
    send_pad('0, '0, '0, 32'd10);
    send_terrain(TERR_SAFE);
    send_pad(button_bit(auto_idx), '0, '0, 32'd20);
    send_pad('0, '0, '0, 32'd30);
    send_terrain(TERR_SLOW);
    send_pad('0, '0, '0, 32'd40);
    // unknown level keeps slow
    send_terrain(TERR_UNKNOWN);
    send_pad('0, '0, '0, 32'd50);
    send_terrain(TERR_STOP);
    send_pad(button_bit(obstacle_idx), '0, '0, 32'd60);
    send_pad(button_bit(deadman_idx), '0, '0, 32'd70);
    send_pad('1, PAD_NEG, PAD_NEG, '1);
    // tick counter wraps
    send_pad('0, '0, '0, '0);
    // a step, a held step, a release, then a wrong press
    send_pad('0, '0, PAD_POS, last_step_ts + 1);
    send_pad('0, '0, PAD_POS, last_step_ts + 1);
    send_pad('0, PAD_ALT, PAD_ALT, last_step_ts + 1);
    send_pad('0, '0, PAD_NEG, last_step_ts + 1);
    // a step, one too late, then one exactly on the limit
    send_pad('0, '0, PAD_POS, last_step_ts + 1);
    send_pad('0, '0, '0, last_step_ts + step_timeout + 1);
    send_pad('0, '0, PAD_POS, last_step_ts + step_timeout);
    drain_results();
  endtask

  // button positions beyond the pad, and deadman sharing the auto position
  task automatic test_button_index_extremes();
    write_setup(4'd15, 4'd11, 4'd14, 32'd1000, 16'd128);
    send_pad('1, '0, '0, last_step_ts);
    send_pad('0, '0, '0, last_step_ts);
    send_pad(11'h400, '0, '0, last_step_ts);
    write_setup(4'd10, 4'd10, 4'd0, 32'd1000, 16'd200);
    send_terrain(TERR_SLOW);
    send_pad(11'h400, '0, '0, last_step_ts);
    send_pad('0, '0, '0, last_step_ts);
    send_pad(11'h001, '0, '0, last_step_ts);
    send_pad(11'h002, '0, '0, last_step_ts);
    drain_results();
  endtask

  task automatic test_random_phase(input int count, input int sender_pct,
                                   input int receiver_pct, input logic [IDX_W-1:0] dead,
                                   input logic [IDX_W-1:0] aut, input logic [IDX_W-1:0] obst,
                                   input logic [TS_W-1:0] timeout,
                                   input logic [SPEED_W-1:0] slow);
    int n;
    write_setup(dead, aut, obst, timeout, slow);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    unlock_run    = 0;
    for (n = 0; n < count; n++) begin
      send_random_report();
      // sender pauses until the block has answered everything
      if (n % 250 == 249) drain_results();
    end
    drain_results();
  endtask

  // long output hold while items keep coming, so the input side stalls
  task automatic test_backpressure();
    int n;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_budget  = stall_served + 250;
    for (n = 0; n < 40; n++) send_random_report();
    drain_results();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tuser     = CMD_GAMEPAD;
    in_tdata     = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    deadman_idx  = 4'd1;
    auto_idx     = 4'd2;
    obstacle_idx = 4'd3;
    step_timeout = 32'd1000;
    slow_speed   = 16'd128;
    terrain      = TERR_STOP;
    auto_mode    = 1'b0;
    auto_held    = 1'b0;
    deadman_held = 1'b0;
    unlock_pos   = 0;
    last_step_ts = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 20;
    recv_idle_pct = 20;
    test_directed_reports();
    test_button_index_extremes();
    test_random_phase(500, 9, 81, 4'd0, 4'd10, 4'd5, '1, '1);
    test_random_phase(500, 81, 9, 4'd10, 4'd0, 4'd1, '0, '0);
    test_random_phase(500, 0, 0, 4'd1, 4'd2, 4'd3, 32'd50, 16'd128);
    test_backpressure();
    drain_results();
    repeat (8) @(posedge clk);

    if (mismatches == 0 && exp_taken == exp_sent) begin
      $display("teleop_drive_mode_safety_arbiter regression: pass");
    end else begin
      $display("teleop_drive_mode_safety_arbiter regression: fail");
    end
    $finish;
  end

endmodule
